### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers on clk_i and rst_ni for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk_i, switched off while in reset
`define SRCC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srcc assertion failed");

// Concurrent assertion sampled on clk_i that also holds during reset
`define SRCC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("srcc reset assertion failed");

`endif

### rtl/srcc_pkg.sv
// ----------------------------------------------------------------------------
// srcc_pkg
// Types, constants and the CRC byte update shared by the reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

package srcc_pkg;

  // Scan window and value layout
  localparam int unsigned WinLen    = 45;
  localparam int unsigned NumVals   = 9;
  localparam int unsigned TagStride = 5;
  localparam int unsigned CntW      = $clog2(WinLen + 1);

  // Stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned ValsW    = NumVals * 32;
  localparam int unsigned OutBits  = 2 + ValsW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - OutBits;

  // CRC-16, MSB first
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  // Tag byte in front of each value
  localparam logic [7:0] TagBytes [NumVals] = '{
    8'h05, 8'h18, 8'h19, 8'h15, 8'h16, 8'h17, 8'h4A, 8'h4B, 8'h4C
  };

  typedef logic [NumVals-1:0][31:0] vals_t;

  // Outcome of one byte step of the packet scanner
  typedef struct packed {
    logic  crc_ok;
    logic  match;
    vals_t values;
  } scan_res_t;

  // Fold one byte into the CRC, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/srcc_scan.sv
// ----------------------------------------------------------------------------
// srcc_scan
// Per-packet state: byte window, running CRC, byte count, match flag and
// candidate values. Reports the end-of-packet outcome for the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module srcc_scan import srcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output scan_res_t  res_o
);

  logic [7:0]      win_q [WinLen];
  logic [7:0]      win_d [WinLen];
  logic [15:0]     crc_q, crc_d, crc_next;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_next;
  logic            match_q, match_d, match_next;
  logic            hit;
  vals_t           cand_q, cand_next, vals;

  // Shift the new byte into the window
  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WinLen-1] = byte_i;
  end

  // Advance CRC over the byte two places back, count up to the window length
  always_comb begin
    crc_next = (cnt_q >= CntW'(2)) ? crc_byte(crc_q, win_q[WinLen-2]) : crc_q;
    cnt_next = (cnt_q == CntW'(WinLen)) ? cnt_q : cnt_q + CntW'(1);
  end

  // Compare tags on the full window and pull out the values, first byte low
  always_comb begin
    hit = (cnt_next == CntW'(WinLen));
    for (int i = 0; i < NumVals; i++) begin
      if (win_d[TagStride*i] != TagBytes[i]) begin
        hit = 1'b0;
      end
      vals[i] = {win_d[TagStride*i+4], win_d[TagStride*i+3],
                 win_d[TagStride*i+2], win_d[TagStride*i+1]};
    end
    match_next = match_q | hit;
    cand_next  = hit ? vals : cand_q;
  end

  // Outcome if this byte closes the packet
  always_comb begin
    res_o.crc_ok = (cnt_next >= CntW'(2)) &&
                   (crc_next == {win_d[WinLen-2], win_d[WinLen-1]});
    res_o.match  = match_next;
    res_o.values = cand_next;
  end

  // Drop packet state after the last byte
  always_comb begin
    if (last_i) begin
      crc_d   = '0;
      cnt_d   = '0;
      match_d = 1'b0;
    end else begin
      crc_d   = crc_next;
      cnt_d   = cnt_next;
      match_d = match_next;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      cnt_q   <= '0;
      match_q <= 1'b0;
    end else if (step_i) begin
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
    end
  end

  // Window and candidates are only read once the count or match flag says so
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q  <= win_d;
      cand_q <= cand_next;
    end
  end

endmodule

`default_nettype wire

### rtl/sensor_reply_crc_check_and_extract_core.sv
// ----------------------------------------------------------------------------
// sensor_reply_crc_check_and_extract_core
// Checks the CRC-16 of sensor reply packets and extracts nine tagged values.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one packet byte per transfer in tdata[7:0]; tlast
//   marks the final byte. Bytes are not echoed: only the final byte of a
//   packet produces one master transfer with crc_ok, pattern_found and the
//   nine held 32-bit values (yaw, pitch, roll, accel x/y/z, gyro x/y/z).
//   The last two bytes of a packet are its CRC, big-endian. Held values are
//   replaced only when the CRC passes and the tagged layout was seen.
//   A final byte is taken into the input register and then processed into
//   the result register that drives tvalid.
//   Throughput: one byte per cycle unless a final byte waits; the window
//   shift, unrolled CRC byte update and tag compare sit between registers.
//   Reset clears the packet state, the held values and both valid flags.
//   While a result waits on tready, further non-final bytes keep flowing;
//   a final byte waits in the input register until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_reply_crc_check_and_extract_core import srcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Slave stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                s_axis_tlast_i,   // last_byte
  // Master stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // crc_ok, pattern_found, yaw_bits,
                                                // pitch_bits, roll_bits,
                                                // accel_x_bits .. accel_z_bits,
                                                // gyro_x_bits .. gyro_z_bits,
                                                // zero pad
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       step;
  logic       out_valid_q;
  logic       crc_ok_q;
  logic       found_q;
  vals_t      held_q;
  scan_res_t  res;

  // Process the held byte unless it closes a packet whose result cannot go out
  assign step            = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Packet scanner
  srcc_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  // Result valid: set on a processed final byte, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Held values, replaced only by a good packet with a match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (step && in_last_q && res.crc_ok && res.match) begin
      held_q <= res.values;
    end
  end

  // Result flags
  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      crc_ok_q <= res.crc_ok;
      found_q  <= res.match;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, held_q, found_q, crc_ok_q};

endmodule

`default_nettype wire

### rtl/srcc_checker.sv
// ----------------------------------------------------------------------------
// srcc_checker
// Port-level checks on the reply checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srcc_checker import srcc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [ValsW-1:0] prev_vals_q;
  logic [ValsW-1:0] out_vals;
  logic             good_pkt;
  logic             out_stall;

  assign good_pkt  = m_axis_tdata_o[0] && m_axis_tdata_o[1];
  assign out_vals  = m_axis_tdata_o[ValsW+1:2];
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // Track the values of the last result transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vals_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      prev_vals_q <= out_vals;
    end
  end

  // Stalled result holds
  `SRCC_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // A failed or unmatched packet leaves the held values alone
  `SRCC_ASSERT(a_vals_kept, m_axis_tvalid_o && !good_pkt |-> out_vals == prev_vals_q)

  // Input only stalls behind a blocked result
  `SRCC_ASSERT(a_in_stall, !s_axis_tready_o |-> out_stall)

  // No result while in reset
  `SRCC_ASSERT_RST(a_rst_quiet, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind sensor_reply_crc_check_and_extract_core srcc_checker u_srcc_checker (.*);

`default_nettype wire
